FILE: design/bfmd_pkg.sv
// Shared types and constants of the box-filter mip downscaler.
package bfmd_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_LEVEL = 5;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int NUM_CH = PIX_W / CH_W;
    localparam int CFG_W  = 13;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int H_W    = $clog2(HEIGHT_LIMIT + 1);

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_MIP_LEVEL  = 2'd2
    } t_cfg_reg;

    // per-pixel block decode from the scan stage
    typedef struct packed {
        logic active;   // pixel lies inside a whole block
        logic first;    // top-left of its block
        logic last;     // bottom-right of its block
        logic eor;
        logic eoi;
    } t_blk_flags;

    typedef struct packed {
        logic [PIX_W-1:0] mip_pixel;
        logic             end_of_row;
        logic             end_of_image;
    } t_mip_beat;

endpackage

FILE: design/bfmd_pix_if.sv
// Source pixel channel.
interface bfmd_pix_if import bfmd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] source_pixel;

    modport source (output valid, output source_pixel, input ready);
    modport sink   (input valid, input source_pixel, output ready);
endinterface

FILE: design/bfmd_mip_if.sv
// Averaged pixel channel.
interface bfmd_mip_if import bfmd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mip_pixel;
    logic             end_of_row;
    logic             end_of_image;

    modport source (output valid, output mip_pixel, output end_of_row, output end_of_image,
                    input ready);
    modport sink   (input valid, input mip_pixel, input end_of_row, input end_of_image,
                    output ready);
endinterface

FILE: design/bfmd_ram.sv
// Generic simple dual-port RAM with registered read.
module bfmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: design/bfmd_scan.sv
// Config registers, raster position counters and block decode of the incoming pixel.
module bfmd_scan import bfmd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_LEVEL = DEF_MAX_LEVEL
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [CFG_W-1:0]                 i_cfg_data,
    input  logic                             i_accept,
    output t_blk_flags                       o_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_addr,
    output logic [$clog2(MAX_LEVEL+1)-1:0]   o_lvl
);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int LV_W  = $clog2(MAX_LEVEL + 1);

    logic [CFG_W-1:0] r_src_w, r_src_h;
    logic [2:0]       r_lvl;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [31:0]      w32, h32;
    logic [EW-1:0]    eff_w, wmask, out_w;
    logic [H_W-1:0]   eff_h, hmask, out_h;
    logic [LV_W-1:0]  lv;
    logic [COL_W-1:0] cmask, xx, ox;
    logic [ROW_W-1:0] rmask, yy, oy;

    always_comb begin
        if (r_src_w == '0) begin
            w32 = 32'd1;
        end else if (32'(r_src_w) > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end else begin
            w32 = 32'(r_src_w);
        end
        if (r_src_h == '0) begin
            h32 = 32'd1;
        end else if (32'(r_src_h) > 32'(HEIGHT_LIMIT)) begin
            h32 = 32'(HEIGHT_LIMIT);
        end else begin
            h32 = 32'(r_src_h);
        end
        eff_w = w32[EW-1:0];
        eff_h = h32[H_W-1:0];
        if (32'(r_lvl) > 32'(MAX_LEVEL)) begin
            lv = LV_W'(MAX_LEVEL);
        end else begin
            lv = r_lvl[LV_W-1:0];
        end

        cmask = ~({COL_W{1'b1}} << lv);
        rmask = ~({ROW_W{1'b1}} << lv);
        wmask = ~({EW{1'b1}} << lv);
        hmask = ~({H_W{1'b1}} << lv);
        xx    = r_col & cmask;
        yy    = r_row & rmask;
        ox    = r_col >> lv;
        oy    = r_row >> lv;
        out_w = eff_w >> lv;
        out_h = eff_h >> lv;

        o_flags.active = (EW'(r_col) < (eff_w & ~wmask)) && (H_W'(r_row) < (eff_h & ~hmask));
        o_flags.first  = (xx == '0) && (yy == '0);
        o_flags.last   = (xx == cmask) && (yy == rmask);
        o_flags.eor    = (EW'(ox) == out_w - EW'(1));
        o_flags.eoi    = o_flags.eor && (H_W'(oy) == out_h - H_W'(1));
        o_addr         = ox;
        o_lvl          = lv;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept) begin
            if (EW'(r_col) + EW'(1) >= eff_w) begin
                n_col = '0;
                if (H_W'(r_row) + H_W'(1) >= eff_h) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CFG_W'(4096);
            r_src_h <= CFG_W'(4096);
            r_lvl   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                    REG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                    REG_MIP_LEVEL:  r_lvl   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: design/bfmd_accum.sv
// Column accumulator RAM with read-modify-write and last-write forwarding.
module bfmd_accum import bfmd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_LEVEL = DEF_MAX_LEVEL
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  t_blk_flags                     i_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_addr,
    input  logic [PIX_W-1:0]               i_pixel,
    input  logic [$clog2(MAX_LEVEL+1)-1:0] i_lvl,
    output logic                           o_res_valid,
    output t_mip_beat                      o_res
);
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int SUM_W  = CH_W + 2 * MAX_LEVEL;
    localparam int WORD_W = NUM_CH * SUM_W;

    logic              r_s1_act;
    t_blk_flags        r_s1_flags;
    logic [AW-1:0]     r_s1_addr;
    logic [PIX_W-1:0]  r_s1_pix;
    logic              r_lw_valid;
    logic [AW-1:0]     r_lw_addr;
    logic [WORD_W-1:0] r_lw_data;

    logic [WORD_W-1:0] ram_rdata, base, n_sums;
    logic [PIX_W-1:0]  res_pix;

    bfmd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_act),
        .i_waddr (r_s1_addr),
        .i_wdata (n_sums),
        .i_re    (i_accept && i_flags.active),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    // the RAM returns old data when the previous beat wrote the same column
    always_comb begin
        logic [CH_W-1:0]  ch;
        logic [SUM_W-1:0] avg;
        base = (r_lw_valid && r_lw_addr == r_s1_addr) ? r_lw_data : ram_rdata;
        for (int c = 0; c < NUM_CH; c++) begin
            ch = r_s1_pix[c*CH_W +: CH_W];
            if (r_s1_flags.first) begin
                n_sums[c*SUM_W +: SUM_W] = SUM_W'(ch);
            end else begin
                n_sums[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] + SUM_W'(ch);
            end
            avg = n_sums[c*SUM_W +: SUM_W] >> {i_lvl, 1'b0};
            res_pix[c*CH_W +: CH_W] = avg[CH_W-1:0];
        end
    end

    assign o_res_valid        = r_s1_act && r_s1_flags.last;
    assign o_res.mip_pixel    = res_pix;
    assign o_res.end_of_row   = r_s1_flags.eor;
    assign o_res.end_of_image = r_s1_flags.eoi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_act   <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            r_s1_act <= i_accept && i_flags.active;
            if (r_s1_act) begin
                r_lw_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_flags <= i_flags;
            r_s1_addr  <= i_addr;
            r_s1_pix   <= i_pixel;
        end
        if (r_s1_act) begin
            r_lw_addr <= r_s1_addr;
            r_lw_data <= n_sums;
        end
    end
endmodule

FILE: design/bfmd_outq.sv
// Small output queue that decouples the result stage from the receiver.
module bfmd_outq import bfmd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_mip_beat          i_beat,
    output logic [OQ_CW-1:0]   o_count,
    bfmd_mip_if.source         o_mip
);
    t_mip_beat        r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_CW-1:0] r_cnt;
    logic             pop;

    assign pop                = o_mip.valid && o_mip.ready;
    assign o_mip.valid        = (r_cnt != '0);
    assign o_mip.mip_pixel    = r_q[r_rp].mip_pixel;
    assign o_mip.end_of_row   = r_q[r_rp].end_of_row;
    assign o_mip.end_of_image = r_q[r_rp].end_of_image;
    assign o_count            = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + OQ_CW'(i_push) - OQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_beat;
        end
    end
endmodule

FILE: design/box_filter_mip_downscale_top.sv
// Box-filter mipmap downscaler for ARGB8888 raster streams.
//
// i_pix carries source pixels in raster order, one beat per pixel; o_mip carries one
// averaged pixel per 2^L x 2^L block, with end_of_row / end_of_image marks. The
// config port (i_cfg_we, i_cfg_index, i_cfg_data) sets width, height and level;
// any write restarts the image at the top-left. Write only while the block is idle.
//
// Throughput: one source pixel per clock while the output queue has room. Each pixel does one
// read-modify-write of its output column's channel sums in the accumulator RAM
// (read is registered; add and write-back follow in the next cycle); a back-to-back hit
// on the same column is served from the last-write register.
// Path: last pixel of a block -> accumulator stage register -> output queue -> o_mip.
//
// Reset: width and height 4096, level 0, position zero, output queue empty. The
// sum RAM is not cleared; the top-left pixel of each block writes its sums fresh.
// Receiver stall: results wait in a four-beat queue; i_pix.ready drops once the
// queue plus the result in flight reach three beats.
module box_filter_mip_downscale_top import bfmd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_LEVEL = DEF_MAX_LEVEL
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bfmd_pix_if.sink             i_pix,
    bfmd_mip_if.source           o_mip
);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int LV_W = $clog2(MAX_LEVEL + 1);

    logic             accept;
    t_blk_flags       flags;
    logic [AW-1:0]    addr;
    logic [LV_W-1:0]  lvl;
    logic             res_valid;
    t_mip_beat        res;
    logic [OQ_CW-1:0] oq_cnt;

    assign i_pix.ready = (oq_cnt + OQ_CW'(res_valid)) <= OQ_CW'(OQ_DEPTH - 2);
    assign accept      = i_pix.valid && i_pix.ready;

    bfmd_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LEVEL (MAX_LEVEL)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_flags     (flags),
        .o_addr      (addr),
        .o_lvl       (lvl)
    );

    bfmd_accum #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LEVEL (MAX_LEVEL)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_flags     (flags),
        .i_addr      (addr),
        .i_pixel     (i_pix.source_pixel),
        .i_lvl       (lvl),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bfmd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_beat  (res),
        .o_count (oq_cnt),
        .o_mip   (o_mip)
    );
endmodule
